// ----- hdl/ptz_reply_frame_decoder_top_macros.svh -----
// Assertion shorthands for the checker file of this block.
`ifndef PTZ_REPLY_FRAME_DECODER_TOP_MACROS_SVH
`define PTZ_REPLY_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define PTZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptz reply decoder: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define PTZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptz reply decoder: next-cycle check failed");

`endif

// ----- hdl/ptz_rfd_pkg.sv -----
`default_nettype none

package ptz_rfd_pkg;

    typedef enum logic [2:0] {
        KIND_BYTE      = 3'd0,
        KIND_ARM       = 3'd1,
        KIND_PAN_TGT   = 3'd2,
        KIND_TILT_TGT  = 3'd3,
        KIND_ZOOM_TGT  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        EXP_NONE     = 2'd0,
        EXP_GENERAL  = 2'd1,
        EXP_EXTENDED = 2'd2,
        EXP_QUERY    = 2'd3
    } t_expect;

    typedef enum logic [2:0] {
        ITEM_NONE = 3'd0,
        ITEM_PAN  = 3'd1,
        ITEM_TILT = 3'd2,
        ITEM_ZOOM = 3'd3,
        ITEM_MAG  = 3'd4
    } t_item;

    localparam logic [7:0]  C_SYNC_BYTE = 8'hFF;
    localparam logic [7:0]  C_CODE_PAN  = 8'h59;
    localparam logic [7:0]  C_CODE_TILT = 8'h5B;
    localparam logic [7:0]  C_CODE_ZOOM = 8'h5D;
    localparam logic [7:0]  C_CODE_MAG  = 8'h63;

    localparam logic [4:0]  C_LEN_QUERY    = 5'd18;
    localparam logic [4:0]  C_LEN_EXTENDED = 5'd7;
    localparam logic [4:0]  C_LEN_GENERAL  = 5'd4;

    localparam logic [15:0] C_ZOOM_TOL_RESET = 16'd700;

    // Register select: paddr bit 2 picks the 32-bit word.
    localparam logic        C_REG_ZOOM_TOL = 1'b0;
    localparam int          C_PADDR_W      = 3;

    typedef struct packed {
        logic [7:0]  reply_code;
        t_item       updated_item;
        logic [15:0] position_value;
        logic [15:0] captured_value;
        logic        captured;
        logic        target_reached;
        logic        zoom_changed;
        logic        position_synced;
        logic        zoom_synced;
        logic        wake_waiter;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/ptz_rfd_if.sv -----
`default_nettype none

interface ptz_rfd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  rx_byte;
    logic [1:0]  expected_response;
    logic [15:0] target_value;

    modport source (output valid, kind, rx_byte, expected_response, target_value,
                    input ready);
    modport sink   (input valid, kind, rx_byte, expected_response, target_value,
                    output ready);
endinterface

interface ptz_rfd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reply_code;
    logic [2:0]  updated_item;
    logic [15:0] position_value;
    logic [15:0] captured_value;
    logic        captured;
    logic        target_reached;
    logic        zoom_changed;
    logic        position_synced;
    logic        zoom_synced;
    logic        wake_waiter;

    modport source (output valid, reply_code, updated_item, position_value,
                    captured_value, captured, target_reached, zoom_changed,
                    position_synced, zoom_synced, wake_waiter,
                    input ready);
    modport sink   (input valid, reply_code, updated_item, position_value,
                    captured_value, captured, target_reached, zoom_changed,
                    position_synced, zoom_synced, wake_waiter,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/ptz_rfd_core.sv -----
`default_nettype none

module ptz_rfd_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [2:0]             i_kind,
    input  wire logic [7:0]             i_rx_byte,
    input  wire logic [1:0]             i_expected,
    input  wire logic [15:0]            i_target,
    input  wire logic [15:0]            i_zoom_tol,
    output ptz_rfd_pkg::t_result        o_res,
    output logic                        o_res_valid
);

    logic [4:0]  r_count, n_count;
    logic [4:0]  r_len, n_len;
    logic [7:0]  r_rb0, n_rb0, r_rb1, n_rb1, r_rb2, n_rb2;
    logic [15:0] r_pan_tgt, n_pan_tgt, r_tilt_tgt, n_tilt_tgt;
    logic [15:0] r_zoom_tgt, n_zoom_tgt, r_last_zoom, n_last_zoom;
    logic        r_mon, n_mon, r_pan_seen, n_pan_seen, r_tilt_seen, n_tilt_seen;

    logic        w_is_byte, w_in_frame, w_last, w_fire;
    logic [4:0]  w_cnt_inc;
    logic [7:0]  w_rb0, w_rb1, w_rb2;
    logic [15:0] w_raw, w_dist, w_pos;
    logic [16:0] w_diff;
    logic        w_pan, w_tilt, w_zoom, w_mag, w_pan_hit, w_tilt_hit, w_zoom_hit;
    logic        w_cap, w_pan_seen, w_tilt_seen, w_psync;

    // Frame position and byte capture; bytes 3..5 are folded in before the
    // frame-end check so a short frame sees its own code byte.
    assign w_is_byte  = (i_kind == ptz_rfd_pkg::KIND_BYTE);
    assign w_in_frame = w_is_byte && (r_count != 5'd0);
    assign w_cnt_inc  = r_count + 5'd1;
    assign w_last     = w_in_frame && (w_cnt_inc >= r_len);
    assign w_fire     = i_accept && w_last;

    assign w_rb0 = (w_in_frame && r_count == 5'd3) ? i_rx_byte : r_rb0;
    assign w_rb1 = (w_in_frame && r_count == 5'd4) ? i_rx_byte : r_rb1;
    assign w_rb2 = (w_in_frame && r_count == 5'd5) ? i_rx_byte : r_rb2;
    assign w_raw = {w_rb1, w_rb2};

    assign w_pan  = (w_rb0 == ptz_rfd_pkg::C_CODE_PAN);
    assign w_tilt = (w_rb0 == ptz_rfd_pkg::C_CODE_TILT);
    assign w_zoom = (w_rb0 == ptz_rfd_pkg::C_CODE_ZOOM);
    assign w_mag  = (w_rb0 == ptz_rfd_pkg::C_CODE_MAG);

    assign w_diff     = {1'b0, r_zoom_tgt} - {1'b0, w_raw};
    assign w_dist     = w_diff[16] ? (w_raw - r_zoom_tgt) : w_diff[15:0];
    assign w_zoom_hit = w_zoom && (w_dist < i_zoom_tol);
    assign w_pan_hit  = w_pan && (r_pan_tgt == w_raw);
    assign w_tilt_hit = w_tilt && (r_tilt_tgt == w_raw);

    // Monitor takes pan, tilt and zoom; the reported value drops to zero.
    assign w_cap = r_mon && (w_pan || w_tilt || w_zoom);
    assign w_pos = ((w_pan || w_tilt || w_zoom || w_mag) && !w_cap) ? w_raw : 16'd0;

    assign w_pan_seen  = r_pan_seen  || w_pan;
    assign w_tilt_seen = r_tilt_seen || w_tilt;
    assign w_psync     = w_pan_seen && w_tilt_seen;

    always_comb begin
        o_res.reply_code      = w_rb0;
        o_res.updated_item    = ptz_rfd_pkg::ITEM_NONE;
        if (w_pan) begin
            o_res.updated_item = ptz_rfd_pkg::ITEM_PAN;
        end else if (w_tilt) begin
            o_res.updated_item = ptz_rfd_pkg::ITEM_TILT;
        end else if (w_zoom) begin
            o_res.updated_item = ptz_rfd_pkg::ITEM_ZOOM;
        end else if (w_mag) begin
            o_res.updated_item = ptz_rfd_pkg::ITEM_MAG;
        end
        o_res.position_value  = w_pos;
        o_res.captured_value  = w_cap ? w_raw : 16'd0;
        o_res.captured        = w_cap;
        o_res.target_reached  = w_pan_hit || w_tilt_hit || w_zoom_hit;
        o_res.zoom_changed    = w_zoom && (w_pos != r_last_zoom);
        o_res.position_synced = w_psync;
        o_res.zoom_synced     = w_zoom;
        o_res.wake_waiter     = (i_expected != ptz_rfd_pkg::EXP_NONE);
    end

    assign o_res_valid = w_fire;

    always_comb begin
        n_count     = r_count;
        n_len       = r_len;
        n_rb0       = r_rb0;
        n_rb1       = r_rb1;
        n_rb2       = r_rb2;
        n_pan_tgt   = r_pan_tgt;
        n_tilt_tgt  = r_tilt_tgt;
        n_zoom_tgt  = r_zoom_tgt;
        n_last_zoom = r_last_zoom;
        n_mon       = r_mon;
        n_pan_seen  = r_pan_seen;
        n_tilt_seen = r_tilt_seen;
        if (i_accept) begin
            unique case (i_kind)
                ptz_rfd_pkg::KIND_ARM:      n_mon      = 1'b1;
                ptz_rfd_pkg::KIND_PAN_TGT:  n_pan_tgt  = i_target;
                ptz_rfd_pkg::KIND_TILT_TGT: n_tilt_tgt = i_target;
                ptz_rfd_pkg::KIND_ZOOM_TGT: n_zoom_tgt = i_target;
                ptz_rfd_pkg::KIND_BYTE: begin
                    if (r_count == 5'd0) begin
                        // Hunt for sync while a reply is expected; drop anything else.
                        if (i_rx_byte == ptz_rfd_pkg::C_SYNC_BYTE &&
                            i_expected != ptz_rfd_pkg::EXP_NONE) begin
                            n_count = 5'd1;
                            unique case (i_expected)
                                ptz_rfd_pkg::EXP_QUERY:    n_len = ptz_rfd_pkg::C_LEN_QUERY;
                                ptz_rfd_pkg::EXP_EXTENDED: n_len = ptz_rfd_pkg::C_LEN_EXTENDED;
                                default:                   n_len = ptz_rfd_pkg::C_LEN_GENERAL;
                            endcase
                        end
                    end else begin
                        n_rb0 = w_rb0;
                        n_rb1 = w_rb1;
                        n_rb2 = w_rb2;
                        if (w_last) begin
                            n_count = 5'd0;
                            n_len   = 5'd0;
                            if (w_pan_hit) begin
                                n_pan_tgt = 16'd0;
                            end
                            if (w_tilt_hit) begin
                                n_tilt_tgt = 16'd0;
                            end
                            if (w_zoom_hit) begin
                                n_zoom_tgt = 16'd0;
                            end
                            if (w_zoom) begin
                                n_mon       = 1'b0;
                                n_last_zoom = w_pos;
                            end
                            n_pan_seen  = w_psync ? 1'b0 : w_pan_seen;
                            n_tilt_seen = w_psync ? 1'b0 : w_tilt_seen;
                        end else begin
                            n_count = w_cnt_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 5'd0;
            r_len       <= 5'd0;
            r_rb0       <= 8'd0;
            r_rb1       <= 8'd0;
            r_rb2       <= 8'd0;
            r_pan_tgt   <= 16'd0;
            r_tilt_tgt  <= 16'd0;
            r_zoom_tgt  <= 16'd0;
            r_last_zoom <= 16'd0;
            r_mon       <= 1'b0;
            r_pan_seen  <= 1'b0;
            r_tilt_seen <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_len       <= n_len;
            r_rb0       <= n_rb0;
            r_rb1       <= n_rb1;
            r_rb2       <= n_rb2;
            r_pan_tgt   <= n_pan_tgt;
            r_tilt_tgt  <= n_tilt_tgt;
            r_zoom_tgt  <= n_zoom_tgt;
            r_last_zoom <= n_last_zoom;
            r_mon       <= n_mon;
            r_pan_seen  <= n_pan_seen;
            r_tilt_seen <= n_tilt_seen;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ptz_rfd_obuf.sv -----
`default_nettype none

module ptz_rfd_obuf (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire ptz_rfd_pkg::t_result   i_data,
    output logic                        o_ready,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output ptz_rfd_pkg::t_result        o_data
);

    logic                 r_main_v, n_main_v, r_skid_v, n_skid_v;
    ptz_rfd_pkg::t_result r_main, n_main, r_skid, n_skid;
    logic                 w_pop;

    assign w_pop   = r_main_v && i_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    // Push only lands while the skid slot is empty.
    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (w_pop || !r_main_v) begin
            n_main_v = r_skid_v || i_push;
            n_main   = r_skid_v ? r_skid : i_data;
            n_skid_v = 1'b0;
        end else if (i_push) begin
            n_skid_v = 1'b1;
            n_skid   = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ----- hdl/ptz_reply_frame_decoder_top.sv -----
`default_nettype none
// Channel   Dir  Handshake        Beat
// i_req     in   valid / ready    kind, rx_byte, expected_response, target_value
// o_rsp     out  valid / ready    reply_code, updated_item, position_value, ...
// APB       in   psel/penable     zoom_tolerance at byte address 0
//
// One request beat is taken per clock while the result queue has room;
// a beat that completes a frame is registered in the result queue, then shows on o_rsp.
// The decode (sync hunt, byte capture, target compare) is a single
// combinational pass from the frame state registers into a two-entry
// result queue, so o_rsp stalls never block the cycle they start in.
// i_rst_n is synchronous, active low; it clears the frame state, targets,
// monitor, sync flags and restores zoom_tolerance to 700.

module ptz_reply_frame_decoder_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    ptz_rfd_req_if.sink                                i_req,
    ptz_rfd_rsp_if.source                              o_rsp,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ptz_rfd_pkg::C_PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    logic [15:0]          r_zoom_tol;
    logic                 w_accept, w_res_valid, w_q_ready, w_cfg_wr;
    ptz_rfd_pkg::t_result w_res, w_out;

    // Configuration: single word, written on the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite &&
                      (paddr[2] == ptz_rfd_pkg::C_REG_ZOOM_TOL);
    assign prdata   = (paddr[2] == ptz_rfd_pkg::C_REG_ZOOM_TOL) ?
                      {16'd0, r_zoom_tol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom_tol <= ptz_rfd_pkg::C_ZOOM_TOL_RESET;
        end else if (w_cfg_wr) begin
            r_zoom_tol <= pwdata[15:0];
        end
    end

    // Take a beat whenever the result queue can absorb one more result.
    assign i_req.ready = w_q_ready;
    assign w_accept    = i_req.valid && w_q_ready;

    ptz_rfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (i_req.kind),
        .i_rx_byte   (i_req.rx_byte),
        .i_expected  (i_req.expected_response),
        .i_target    (i_req.target_value),
        .i_zoom_tol  (r_zoom_tol),
        .o_res       (w_res),
        .o_res_valid (w_res_valid)
    );

    ptz_rfd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_ready (w_q_ready),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (w_out)
    );

    assign o_rsp.reply_code      = w_out.reply_code;
    assign o_rsp.updated_item    = w_out.updated_item;
    assign o_rsp.position_value  = w_out.position_value;
    assign o_rsp.captured_value  = w_out.captured_value;
    assign o_rsp.captured        = w_out.captured;
    assign o_rsp.target_reached  = w_out.target_reached;
    assign o_rsp.zoom_changed    = w_out.zoom_changed;
    assign o_rsp.position_synced = w_out.position_synced;
    assign o_rsp.zoom_synced     = w_out.zoom_synced;
    assign o_rsp.wake_waiter     = w_out.wake_waiter;

endmodule

`default_nettype wire

// ----- hdl/ptz_rfd_checker.sv -----
`default_nettype none
`include "ptz_reply_frame_decoder_top_macros.svh"

module ptz_rfd_sva (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready,
    input  wire logic [7:0]  i_code,
    input  wire logic [2:0]  i_item,
    input  wire logic [15:0] i_pos,
    input  wire logic [15:0] i_capv,
    input  wire logic        i_cap,
    input  wire logic        i_reached,
    input  wire logic        i_zsync
);

    logic [44:0] w_beat;

    assign w_beat = {i_code, i_item, i_pos, i_capv, i_cap, i_reached};

    // Hold a stalled result beat.
    `PTZ_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_valid && !i_ready,
                    i_valid && $stable(w_beat))

    // Unknown code reports no item data.
    `PTZ_ASSERT_IMP(a_none_quiet, i_clk, i_rst_n,
                    i_valid && i_item == ptz_rfd_pkg::ITEM_NONE,
                    i_pos == 16'd0 && !i_cap && !i_reached)

    // Capture zeroes the reported position; no capture means no captured value.
    `PTZ_ASSERT_IMP(a_cap_split, i_clk, i_rst_n, i_valid,
                    (i_cap && i_pos == 16'd0) || (!i_cap && i_capv == 16'd0))

    // Zoom sync comes with zoom replies only.
    `PTZ_ASSERT_IMP(a_zsync_item, i_clk, i_rst_n, i_valid,
                    i_zsync == (i_item == ptz_rfd_pkg::ITEM_ZOOM))

endmodule

bind ptz_reply_frame_decoder_top ptz_rfd_sva u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rsp.valid),
    .i_ready   (o_rsp.ready),
    .i_code    (o_rsp.reply_code),
    .i_item    (o_rsp.updated_item),
    .i_pos     (o_rsp.position_value),
    .i_capv    (o_rsp.captured_value),
    .i_cap     (o_rsp.captured),
    .i_reached (o_rsp.target_reached),
    .i_zsync   (o_rsp.zoom_synced)
);

`default_nettype wire
